/* sv/spectral_occupancy_range_tracker_top_assert.svh */
// Assertion helpers for the range tracker
`ifndef SPECTRAL_OCCUPANCY_RANGE_TRACKER_TOP_ASSERT_SVH
`define SPECTRAL_OCCUPANCY_RANGE_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define SORNG_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorng: check failed");

// next-cycle implication
`define SORNG_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorng: check failed");

`endif

/* sv/sorng_pkg.sv */
`default_nettype none
package sorng_pkg;
	localparam int unsigned MAX_RANGES_DEF   = 16;
	localparam int unsigned MAX_CHANNELS_DEF = 16384;

	localparam int SAMPLE_W = 32;
	localparam int LEVEL_W  = 31;
	localparam int MINR_W   = 5;
	localparam int CNT_W    = 32;
	localparam int POS_W    = 14;
	localparam int WID_W    = 15;

	localparam logic [LEVEL_W-1:0] DETECT_RST = 31'd100000;
	localparam logic [LEVEL_W-1:0] CLIP_RST   = 31'd2000000;
	localparam logic [MINR_W-1:0]  MINR_RST   = 5'd2;

	localparam logic [1:0] CFG_DETECT = 2'd0;
	localparam logic [1:0] CFG_CLIP   = 2'd1;
	localparam logic [1:0] CFG_MINR   = 2'd2;

	typedef struct packed {
		logic idx_clr;
		logic idx_inc;
		logic commit;
		logic copy_put;
		logic spec_clear;
	} dp_cmd_t;

	typedef struct packed {
		logic any_flag;
		logic count_diff;
		logic count_zero;
		logic idx_last;
		logic mismatch;
		logic out_free;
		logic emit_en;
	} dp_stat_t;
endpackage
`default_nettype wire

/* sv/sorng_ram.sv */
`default_nettype none
module sorng_ram #(
	parameter int unsigned WIDTH = 28,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [AW-1:0]            raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/sorng_ctrl.sv */
`default_nettype none
module sorng_ctrl import sorng_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept_last,
	input  wire dp_stat_t stat,
	output logic          in_ready,
	output dp_cmd_t       cmd
);
	typedef enum logic [3:0] {
		ST_RUN, ST_ENDS, ST_DECIDE, ST_CMP_RD, ST_CMP_CK,
		ST_COMMIT, ST_CP_RD, ST_CP_PUT, ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_RUN: begin
				if (accept_last) state_d = ST_ENDS;
			end
			ST_ENDS: begin
				// last channel settles in the datapath this cycle
				cmd.idx_clr = 1'b1;
				state_d     = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.any_flag) state_d = ST_FIN;
				else if (stat.count_diff) state_d = ST_COMMIT;
				else if (stat.count_zero) state_d = ST_FIN;
				else state_d = ST_CMP_RD;
			end
			ST_CMP_RD: state_d = ST_CMP_CK;
			ST_CMP_CK: begin
				if (stat.mismatch) begin
					state_d = ST_COMMIT;
				end else if (stat.idx_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_CMP_RD;
				end
			end
			ST_COMMIT: begin
				cmd.commit  = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = stat.count_zero ? ST_FIN : ST_CP_RD;
			end
			ST_CP_RD: state_d = ST_CP_PUT;
			ST_CP_PUT: begin
				// hold until the output register can take the item
				if (!stat.emit_en || stat.out_free) begin
					cmd.copy_put = 1'b1;
					if (stat.idx_last) begin
						state_d = ST_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_CP_RD;
					end
				end
			end
			ST_FIN: begin
				cmd.spec_clear = 1'b1;
				state_d        = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			in_ready <= 1'b1;
		end else begin
			state_q  <= state_d;
			in_ready <= (state_d == ST_RUN) && !(state_q == ST_RUN && accept_last);
		end
	end
endmodule
`default_nettype wire

/* sv/sorng_dp.sv */
`default_nettype none
module sorng_dp import sorng_pkg::*; #(
	parameter int unsigned MAX_RANGES   = MAX_RANGES_DEF,
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_fire,
	input  wire logic signed [SAMPLE_W-1:0] in_re,
	input  wire logic signed [SAMPLE_W-1:0] in_im,
	input  wire logic                       in_flag,
	input  wire logic                       in_last,
	input  wire logic [LEVEL_W-1:0]         detect_level,
	input  wire logic [LEVEL_W-1:0]         clip_level,
	input  wire logic [MINR_W-1:0]          min_report_ranges,
	input  wire dp_cmd_t                    cmd,
	output dp_stat_t                        stat,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [CNT_W-1:0]                out_spec_num,
	output logic [CNT_W-1:0]                out_since,
	output logic [POS_W-1:0]                out_start,
	output logic [POS_W-1:0]                out_stop,
	output logic [WID_W-1:0]                out_width,
	output logic                            out_ovf,
	output logic                            out_last
);
	localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned CIW = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned AW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CW  = $clog2(MAX_RANGES + 1);
	localparam int unsigned RW  = 2 * CHW;

	// stage 1: squares
	logic signed [63:0] sq_re_s1, sq_im_s1;
	logic               vld_s1, flag_s1, last_s1;
	logic [61:0]        det_sq_q, clip_sq_q;

	logic [CIW-1:0] chan_q;
	logic           in_run_q;
	logic [CHW-1:0] run_begin_q;
	logic           any_flag_q, ovf_q;
	logic [CW-1:0]  new_count_q, kept_count_q, idx_q;
	logic [CNT_W-1:0] spec_cnt_q, last_change_q, since_q;
	logic           emit_q;

	logic [63:0]    mag2;
	logic           occ, inrange, run_now, add_rng;
	logic [CHW-1:0] ch, begin_now, add_first, add_last, last_ch;
	logic [RW-1:0]  new_rdata, kept_rdata;
	logic [CHW-1:0] cp_first, cp_last;
	logic [31:0]    first_w, last_w, width_w;
	logic [31:0]    new_count_w, minr_w;

	always_ff @(posedge clk) begin
		sq_re_s1  <= in_re * in_re;
		sq_im_s1  <= in_im * in_im;
		flag_s1   <= in_flag;
		last_s1   <= in_last;
		det_sq_q  <= detect_level * detect_level;
		clip_sq_q <= clip_level * clip_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_fire;
	end

	always_comb begin
		mag2      = 64'(sq_re_s1) + 64'(sq_im_s1);
		occ       = (mag2 > 64'(det_sq_q)) && (mag2 <= 64'(clip_sq_q));
		inrange   = chan_q < CIW'(MAX_CHANNELS);
		ch        = chan_q[CHW-1:0];
		last_ch   = inrange ? ch : CHW'(MAX_CHANNELS - 1);
		run_now   = inrange ? occ : in_run_q;
		begin_now = (inrange && occ && !in_run_q) ? ch : run_begin_q;
		add_rng   = 1'b0;
		add_first = run_begin_q;
		add_last  = ch - 1'b1;
		if (vld_s1) begin
			if (inrange && !occ && in_run_q) begin
				add_rng = 1'b1;
			end else if (last_s1 && run_now) begin
				add_rng   = 1'b1;
				add_first = begin_now;
				add_last  = last_ch;
			end
		end
	end

	logic new_we;
	assign new_we = add_rng && (new_count_q < CW'(MAX_RANGES));

	sorng_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES)) u_new_ram (
		.clk   (clk),
		.we    (new_we),
		.waddr (new_count_q[AW-1:0]),
		.wdata ({add_last, add_first}),
		.raddr (idx_q[AW-1:0]),
		.rdata (new_rdata)
	);

	sorng_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES)) u_kept_ram (
		.clk   (clk),
		.we    (cmd.copy_put),
		.waddr (idx_q[AW-1:0]),
		.wdata (new_rdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (kept_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q        <= '0;
			in_run_q      <= 1'b0;
			run_begin_q   <= '0;
			any_flag_q    <= 1'b0;
			ovf_q         <= 1'b0;
			new_count_q   <= '0;
			kept_count_q  <= '0;
			idx_q         <= '0;
			spec_cnt_q    <= '0;
			last_change_q <= '0;
			since_q       <= '0;
			emit_q        <= 1'b0;
		end else begin
			if (vld_s1) begin
				if (flag_s1) any_flag_q <= 1'b1;
				if (inrange) begin
					in_run_q    <= occ;
					run_begin_q <= begin_now;
					chan_q      <= chan_q + 1'b1;
				end
				if (last_s1) spec_cnt_q <= spec_cnt_q + 1'b1;
			end
			if (new_we) new_count_q <= new_count_q + 1'b1;
			else if (add_rng) ovf_q <= 1'b1;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.commit) begin
				kept_count_q  <= new_count_q;
				last_change_q <= spec_cnt_q;
				since_q       <= spec_cnt_q - last_change_q;
				emit_q        <= (new_count_q != '0) && (new_count_w >= minr_w);
			end
			if (cmd.spec_clear) begin
				chan_q      <= '0;
				in_run_q    <= 1'b0;
				run_begin_q <= '0;
				any_flag_q  <= 1'b0;
				ovf_q       <= 1'b0;
				new_count_q <= '0;
			end
		end
	end

	assign new_count_w = 32'(new_count_q);
	assign minr_w      = 32'(min_report_ranges);

	assign cp_first = new_rdata[CHW-1:0];
	assign cp_last  = new_rdata[RW-1:CHW];
	assign first_w  = 32'(cp_first);
	assign last_w   = 32'(cp_last);
	assign width_w  = last_w - first_w + 32'd1;

	logic out_load;
	assign out_load = cmd.copy_put && emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_spec_num <= spec_cnt_q;
			out_since    <= since_q;
			out_start    <= first_w[POS_W-1:0];
			out_stop     <= last_w[POS_W-1:0];
			out_width    <= width_w[WID_W-1:0];
			out_ovf      <= ovf_q;
			out_last     <= (idx_q + 1'b1) == kept_count_q;
		end
	end

	always_comb begin
		stat.any_flag   = any_flag_q;
		stat.count_diff = new_count_q != kept_count_q;
		stat.count_zero = new_count_q == '0;
		stat.idx_last   = (idx_q + 1'b1) == new_count_q;
		stat.mismatch   = new_rdata != kept_rdata;
		stat.out_free   = !out_valid || out_ready;
		stat.emit_en    = emit_q;
	end
endmodule
`default_nettype wire

/* sv/spectral_occupancy_range_tracker_top.sv */
`default_nettype none
// Channel | Direction | Payload
// s_*     | in        | tdata: sample_re, sample_im; tuser: sample_flagged; tlast: last_channel
// m_*     | out       | tdata: number, since, start, stop, width, overflow; tlast: last_range
// cfg_*   | in        | index 0 detect, 1 clip, 2 min ranges
// Within a spectrum one sample is taken per cycle (squares registered, then compare).
// After the last channel the datapath settles, compares the new range list with the
// kept one and copies and emits a changed list, range by range, paced by the registered
// reads of the two range memories. A stalled output holds the copy loop; input waits
// until done. Reset clears all control; range memories are undefined until written.
module spectral_occupancy_range_tracker_top import sorng_pkg::*; #(
	parameter int unsigned MAX_RANGES   = MAX_RANGES_DEF,
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // [31:0] sample_re, [63:32] sample_im
	input  wire logic [0:0]   s_tuser,   // [0] sample_flagged
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] spectrum_number, [63:32] spectra_since_change, [77:64] range_start,
	// [91:78] range_stop, [106:92] range_width, [107] ranges_overflow, [111:108] zero
	output wire logic [111:0] m_tdata,
	output logic              m_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [30:0]  cfg_data
);
	logic [LEVEL_W-1:0] detect_q, clip_q;
	logic [MINR_W-1:0]  minr_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_fire, accept_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_q <= DETECT_RST;
			clip_q   <= CLIP_RST;
			minr_q   <= MINR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DETECT: detect_q <= cfg_data;
				CFG_CLIP:   clip_q   <= cfg_data;
				CFG_MINR:   minr_q   <= cfg_data[MINR_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_fire     = s_tvalid && s_tready;
	assign accept_last = in_fire && s_tlast;

	sorng_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept_last (accept_last),
		.stat        (stat),
		.in_ready    (s_tready),
		.cmd         (cmd)
	);

	sorng_dp #(.MAX_RANGES(MAX_RANGES), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_fire           (in_fire),
		.in_re             (s_tdata[31:0]),
		.in_im             (s_tdata[63:32]),
		.in_flag           (s_tuser[0]),
		.in_last           (s_tlast),
		.detect_level      (detect_q),
		.clip_level        (clip_q),
		.min_report_ranges (minr_q),
		.cmd               (cmd),
		.stat              (stat),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_spec_num      (m_tdata[31:0]),
		.out_since         (m_tdata[63:32]),
		.out_start         (m_tdata[77:64]),
		.out_stop          (m_tdata[91:78]),
		.out_width         (m_tdata[106:92]),
		.out_ovf           (m_tdata[107]),
		.out_last          (m_tlast)
	);

	assign m_tdata[111:108] = 4'd0;

`include "spectral_occupancy_range_tracker_top_assert.svh"

	`SORNG_AST_NXT(a_stop_after_last, accept_last, !s_tready)
	`SORNG_AST_NOW(a_load_when_free, cmd.copy_put && stat.emit_en, stat.out_free)
	`SORNG_AST_NOW(a_no_commit_bad, cmd.commit, !stat.any_flag)
endmodule
`default_nettype wire

/* tb/spectral_occupancy_range_tracker_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module spectral_occupancy_range_tracker_checker import sorng_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [63:0]  s_tdata,   // [31:0] sample_re, [63:32] sample_im
	input  wire logic [0:0]   s_tuser,   // [0] sample_flagged
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	// [31:0] number, [63:32] since, [77:64] start, [91:78] stop, [106:92] width, [107] overflow
	input  wire logic [111:0] m_tdata,
	input  wire logic         m_tlast,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [30:0]  cfg_data,
	output int unsigned       fail_count,
	output int unsigned       ranges_due,
	output int unsigned       ranges_seen
);
	typedef struct packed {
		logic [31:0] number;
		logic [31:0] since;
		logic [13:0] start;
		logic [13:0] stop;
		logic [14:0] width;
		logic        ovf;
		logic        lastr;
	} range_rep_t;

	range_rep_t range_q[$];

	logic [LEVEL_W-1:0] detect_lv, clip_lv;
	logic [MINR_W-1:0]  min_ranges;
	logic [13:0] kept_first[MAX_RANGES_DEF], kept_end[MAX_RANGES_DEF];
	logic [13:0] cur_first[MAX_RANGES_DEF], cur_end[MAX_RANGES_DEF];
	int unsigned kept_n, cur_n, chan;
	logic        run_open, bad_seen, too_many;
	logic [13:0] run_first;
	logic [31:0] spectra, change_at;

	function automatic logic [63:0] magnitude(logic [31:0] v);
		return v[31] ? {32'd0, 32'(~v + 32'd1)} : {32'd0, v};
	endfunction

	task automatic close_run(logic [13:0] first, logic [13:0] stop);
		if (cur_n < MAX_RANGES_DEF) begin
			cur_first[cur_n] = first;
			cur_end[cur_n] = stop;
			cur_n++;
		end else begin
			too_many = 1'b1;
		end
	endtask

	task automatic track_sample(logic [31:0] re, logic [31:0] im, logic flg, logic lst);
		logic [63:0] a, b, m2;
		logic occ, changed;
		int unsigned ch;
		logic [13:0] lastch;
		logic [31:0] since;
		range_rep_t r;
		ch = chan;
		if (flg)
			bad_seen = 1'b1;
		if (ch < MAX_CHANNELS_DEF) begin
			a = magnitude(re);
			b = magnitude(im);
			m2 = a * a + b * b;
			occ = (m2 > {33'd0, detect_lv} * {33'd0, detect_lv}) &&
				(m2 <= {33'd0, clip_lv} * {33'd0, clip_lv});
			if (occ) begin
				if (!run_open) begin
					run_open = 1'b1;
					run_first = ch[13:0];
				end
			end else if (run_open) begin
				close_run(run_first, 14'(ch - 1));
				run_open = 1'b0;
			end
			chan = ch + 1;
		end
		if (lst) begin
			lastch = (ch < MAX_CHANNELS_DEF) ? ch[13:0] : 14'h3fff;
			if (run_open)
				close_run(run_first, lastch);
			spectra++;
			if (!bad_seen) begin
				changed = (cur_n != kept_n);
				for (int i = 0; i < cur_n && !changed; i++)
					if (cur_first[i] != kept_first[i] || cur_end[i] != kept_end[i])
						changed = 1'b1;
				if (changed) begin
					since = spectra - change_at;
					kept_n = cur_n;
					for (int i = 0; i < cur_n; i++) begin
						kept_first[i] = cur_first[i];
						kept_end[i] = cur_end[i];
					end
					change_at = spectra;
					if (cur_n > 0 && cur_n >= min_ranges) begin
						for (int i = 0; i < cur_n; i++) begin
							r.number = spectra;
							r.since = since;
							r.start = kept_first[i];
							r.stop = kept_end[i];
							r.width = {1'b0, kept_end[i]} - {1'b0, kept_first[i]} + 15'd1;
							r.ovf = too_many;
							r.lastr = (i + 1 == cur_n);
							range_q.insert(range_q.size(), r);
						end
					end
				end
			end
			cur_n = 0;
			chan = 0;
			run_open = 1'b0;
			run_first = '0;
			bad_seen = 1'b0;
			too_many = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		range_rep_t got, want;
		if (!arst_n) begin
			detect_lv = DETECT_RST;
			clip_lv = CLIP_RST;
			min_ranges = MINR_RST;
			kept_n = 0;
			cur_n = 0;
			chan = 0;
			run_open = 1'b0;
			run_first = '0;
			bad_seen = 1'b0;
			too_many = 1'b0;
			spectra = '0;
			change_at = '0;
			range_q.delete();
			fail_count = 0;
			ranges_seen = 0;
			ranges_due = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DETECT: detect_lv = cfg_data;
					CFG_CLIP:   clip_lv = cfg_data;
					CFG_MINR:   min_ranges = cfg_data[MINR_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[77:64], m_tdata[91:78],
					m_tdata[106:92], m_tdata[107], m_tlast};
				ranges_seen++;
				if (range_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected range start %0d stop %0d", $realtime,
							got.start, got.stop);
				end else begin
					want = range_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t range mismatch (expected / actual):", $realtime);
							$display("  number %0d / %0d  since %0d / %0d",
								want.number, got.number, want.since, got.since);
							$display("  start %0d / %0d  stop %0d / %0d  width %0d / %0d",
								want.start, got.start, want.stop, got.stop,
								want.width, got.width);
							$display("  overflow %0b / %0b  last %0b / %0b",
								want.ovf, got.ovf, want.lastr, got.lastr);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				track_sample(s_tdata[31:0], s_tdata[63:32], s_tuser[0], s_tlast);
			ranges_due = range_q.size();
		end
	end
endmodule
`default_nettype wire

/* tb/tb_spectral_occupancy_range_tracker_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_spectral_occupancy_range_tracker_top;
	import sorng_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;     // [31:0] sample_re, [63:32] sample_im
	logic [0:0]   s_tuser = '0;     // [0] sample_flagged
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;          // number, since, start, stop, width, overflow, zero
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [30:0]  cfg_data = '0;

	int unsigned fail_count, ranges_due, ranges_seen;
	int unsigned send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
	int unsigned samples_sent = 0, spectra_sent = 0;
	logic [30:0] detect_cur = DETECT_RST, clip_cur = CLIP_RST;
	bit occ_map[0:63];

	always #1 clk = ~clk;

	spectral_occupancy_range_tracker_top dut (.*);

	spectral_occupancy_range_tracker_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .ranges_due, .ranges_seen
	);

	// receiver: a long hold-off takes priority over random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready = 1'b0;
			hold_cycles--;
		end else begin
			m_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("[spectral_occupancy_range_tracker_top] ERROR");
		$finish;
	end

	task automatic send_raw(logic [31:0] re, logic [31:0] im, bit flg, bit lst);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {im, re};
		s_tuser = flg;
		s_tlast = lst;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (lst)
			spectra_sent++;
	endtask

	function automatic logic [31:0] signed_mag(logic [31:0] m);
		return $urandom_range(1) ? -m : m;
	endfunction

	task automatic send_channel(bit occ, bit flg, bit lst);
		logic [31:0] m, re, im;
		re = '0;
		im = '0;
		if (occ && detect_cur < clip_cur) begin
			m = $urandom_range(clip_cur, detect_cur + 1);
			if ($urandom_range(1)) re = signed_mag(m); else im = signed_mag(m);
		end else if (!occ) begin
			case ($urandom_range(3))
				0: ;
				1: re = signed_mag($urandom_range(detect_cur, 0));
				2: if (clip_cur < 31'h7fffffff)
						im = signed_mag($urandom_range(32'h7fffffff, clip_cur + 1));
					else
						im = 32'h80000000;
				default: begin
					re = $urandom;
					im = $urandom;
				end
			endcase
		end
		send_raw(re, im, flg, lst);
	endtask

	// kind 0 random runs, 1 alternating (overflows storage), 2 resend last pattern
	task automatic send_spectrum(int unsigned nch, int kind, bit flag_it);
		bit on;
		int unsigned bad_ch;
		on = $urandom_range(1);
		bad_ch = $urandom_range(nch - 1);
		if (kind != 2)
			for (int i = 0; i < nch; i++) begin
				if (kind == 1) on = i[0];
				else if ($urandom_range(99) < 35) on = !on;
				occ_map[i] = on;
			end
		for (int i = 0; i < nch; i++)
			send_channel(occ_map[i], flag_it && i == bad_ch, i == nch - 1);
	endtask

	// stop offering items, then wait for every expected result
	task automatic drain(int unsigned extra);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (ranges_due != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		drain(100);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_DETECT) detect_cur = val;
		if (idx == CFG_CLIP) clip_cur = val;
	endtask

	initial begin
		logic [30:0] set_det[7] = '{31'd100000, 31'd0, 31'd5000, 31'h7fffffff,
			31'd1000, 31'd100000, 31'd0};
		logic [30:0] set_clip[7] = '{31'd2000000, 31'h7fffffff, 31'd60000,
			31'h7fffffff, 31'd500, 31'd2000000, 31'd0};
		logic [4:0] set_minr[7] = '{5'd2, 5'd0, 5'd16, 5'd1, 5'd31, 5'd1, 5'd3};
		int unsigned idle_send[4] = '{0, 82, 0, 23};
		int unsigned idle_recv[4] = '{0, 0, 82, 23};
		int unsigned start_cnt, nch, r, wait_left;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edge amplitudes at reset levels: ranges [1,1] [3,4] [7,7]
		for (int k = 0; k < 2; k++) begin
			send_raw(32'h80000000, 32'h80000000, 0, 0);
			send_raw(32'd100001, 32'd0, 0, 0);
			send_raw(32'd100000, 32'd0, 0, 0);
			send_raw(32'd2000000, 32'd0, 0, 0);
			send_raw(32'd0, -32'd2000000, 0, 0);
			send_raw(32'd0, 32'd0, 0, 0);
			send_raw(32'h7fffffff, 32'd1, 0, 0);
			send_raw(-32'd150000, 32'd150000, 0, 1);
		end
		send_raw(32'd200000, 32'd0, 1, 0);
		send_raw(32'd0, 32'd0, 0, 0);
		send_raw(32'd200000, 32'd0, 0, 1);
		send_raw(32'd0, 32'd0, 0, 1);
		send_raw(32'd300000, 32'd0, 0, 1);
		send_spectrum(36, 1, 0);

		for (int p = 0; p < 7; p++) begin
			write_reg(CFG_DETECT, set_det[p]);
			write_reg(CFG_CLIP, set_clip[p]);
			write_reg(CFG_MINR, {26'd0, set_minr[p]});
			send_idle_pct = idle_send[p % 4];
			recv_stall_pct = idle_recv[p % 4];
			if (p == 5)
				hold_cycles = 400;
			start_cnt = samples_sent;
			while (samples_sent - start_cnt < 35) begin
				r = $urandom_range(99);
				if (p == 1 && samples_sent - start_cnt > 25)
					drain(0);
				if (r < 15)
					send_spectrum($urandom_range(40, 34), 1, 0);
				else if (r < 30 && nch > 0)
					send_spectrum(nch, 2, $urandom_range(9) == 0);
				else begin
					nch = $urandom_range(12) == 0 ? 1 : $urandom_range(30, 3);
					send_spectrum(nch, 0, $urandom_range(9) == 0);
				end
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		wait_left = 200000;
		while (ranges_due != 0 && wait_left > 0) begin
			@(posedge clk);
			wait_left--;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d samples in %0d spectra over 7 level settings and 4 idle mixes;",
			samples_sent, spectra_sent);
		$display("checked %0d emitted ranges, %0d still outstanding.", ranges_seen, ranges_due);
		if (fail_count == 0 && ranges_due == 0)
			$display("[spectral_occupancy_range_tracker_top] OK");
		else
			$display("[spectral_occupancy_range_tracker_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

/* spectral_occupancy_range_tracker_top.f */
+incdir+sv
sv/sorng_pkg.sv
sv/sorng_ram.sv
sv/sorng_ctrl.sv
sv/sorng_dp.sv
sv/spectral_occupancy_range_tracker_top.sv
tb/spectral_occupancy_range_tracker_checker.sv
tb/tb_spectral_occupancy_range_tracker_top.sv
